[src/rsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and constants of the RTCP sender report builder: packet
// type codes, result status codes and the command that travels from the
// front end to the serializer.
// ----------------------------------------------------------------------------
package rsr_pkg;

    // Longest CNAME accepted, in bytes.
    localparam int MAX_NAME_BYTES = 255;

    // Default depth of the command queue between front end and serializer.
    localparam int QUEUE_DEPTH = 2;

    // Fixed protocol bytes.
    localparam logic [7:0] SR_FIRST     = 8'h80;   // V=2, P=0, RC=0
    localparam logic [7:0] SDES_FIRST   = 8'h81;   // V=2, P=0, SC=1
    localparam logic [7:0] SR_TYPE      = 8'd200;
    localparam logic [7:0] SDES_TYPE    = 8'd202;
    localparam logic [7:0] SR_LEN_WORDS = 8'd6;
    localparam logic [7:0] CNAME_ITEM   = 8'd1;

    // Bytes from the start of the sender report up to and including the
    // first name byte.
    localparam int HDR_BYTES = 39;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SOURCE = 2'd1;
    localparam logic [1:0] ST_BAD_NAME  = 2'd2;

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_NAME = 2'd1,
        CMD_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  status;
        logic        finish;      // append END byte and padding
        logic [7:0]  len;         // name length of the report
        logic [7:0]  name_byte;
        logic [31:0] ssrc;
        logic [63:0] ntp_time;
        logic [31:0] media_time;
        logic [31:0] sent_packets;
        logic [31:0] sent_octets;
    } t_cmd;

endpackage
`default_nettype wire

[src/rsr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsr_in_if / rsr_out_if
// Valid/ready channels of the report builder: report fields in, packet
// bytes out.
// ----------------------------------------------------------------------------
interface rsr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] ntp_time;
    logic [31:0] media_time;
    logic [31:0] sent_packets;
    logic [31:0] sent_octets;
    logic [7:0]  name_length;
    logic [7:0]  name_byte;

    modport source (
        output valid, ntp_time, media_time, sent_packets, sent_octets,
               name_length, name_byte,
        input  ready
    );
    modport sink (
        input  valid, ntp_time, media_time, sent_packets, sent_octets,
               name_length, name_byte,
        output ready
    );
endinterface

interface rsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic [1:0] status;

    modport source (output valid, out_byte, packet_end, status, input ready);
    modport sink   (input valid, out_byte, packet_end, status, output ready);
endinterface
`default_nettype wire

[src/rsr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsr_front
// Accepts input items, tracks the position within the name and turns each
// item into a serializer command, or drops it.
// ----------------------------------------------------------------------------
module rsr_front
    import rsr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [31:0] i_cfg_wr_data,
    rsr_in_if.sink      i_item,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  wire         i_full
);

    logic [31:0] r_source_id;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_held, n_held;
    logic        r_drop, n_drop;

    logic        accept;
    logic [7:0]  pos_inc;
    logic        done;
    logic        len_ok;

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign pos_inc      = r_pos + 8'd1;
    assign done         = (pos_inc >= r_held);
    assign len_ok       = (i_item.name_length != 8'd0) &&
                          ({1'b0, i_item.name_length} <= 9'(MAX_NAME_BYTES));

    always_comb begin
        n_pos  = r_pos;
        n_held = r_held;
        n_drop = r_drop;
        o_push = 1'b0;

        o_cmd.kind         = CMD_NAME;
        o_cmd.status       = ST_OK;
        o_cmd.finish       = 1'b0;
        o_cmd.len          = r_held;
        o_cmd.name_byte    = i_item.name_byte;
        o_cmd.ssrc         = r_source_id;
        o_cmd.ntp_time     = i_item.ntp_time;
        o_cmd.media_time   = i_item.media_time;
        o_cmd.sent_packets = i_item.sent_packets;
        o_cmd.sent_octets  = i_item.sent_octets;

        if (accept) begin
            if (r_pos != 8'd0) begin
                // Item inside a name: pass its byte on, or drop it.
                n_pos = pos_inc;
                if (done) begin
                    n_pos  = 8'd0;
                    n_held = 8'd0;
                    n_drop = 1'b0;
                end
                if (!r_drop) begin
                    o_push       = 1'b1;
                    o_cmd.finish = done;
                end
            end else if (r_source_id == 32'd0) begin
                o_push       = 1'b1;
                o_cmd.kind   = CMD_ERR;
                o_cmd.status = ST_NO_SOURCE;
                // Swallow the rest of a valid multi-byte name.
                if (len_ok && (i_item.name_length != 8'd1)) begin
                    n_drop = 1'b1;
                    n_held = i_item.name_length;
                    n_pos  = 8'd1;
                end
            end else if (!len_ok) begin
                o_push       = 1'b1;
                o_cmd.kind   = CMD_ERR;
                o_cmd.status = ST_BAD_NAME;
            end else begin
                o_push       = 1'b1;
                o_cmd.kind   = CMD_HDR;
                o_cmd.len    = i_item.name_length;
                o_cmd.finish = (i_item.name_length == 8'd1);
                if (i_item.name_length != 8'd1) begin
                    n_pos  = 8'd1;
                    n_held = i_item.name_length;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id <= 32'd0;
            r_pos       <= 8'd0;
            r_held      <= 8'd0;
            r_drop      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_source_id <= i_cfg_wr_data;
            end
            r_pos  <= n_pos;
            r_held <= n_held;
            r_drop <= n_drop;
        end
    end

endmodule
`default_nettype wire

[src/rsr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsr_queue
// Small register FIFO of serializer commands.
// ----------------------------------------------------------------------------
module rsr_queue
    import rsr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_empty,
    output t_cmd  o_head,
    input  wire   i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[src/rsr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsr_back
// Serializer: walks the command at the head of the queue one byte per
// cycle, while the receiver takes bytes, into a registered output stage.
// ----------------------------------------------------------------------------
module rsr_back
    import rsr_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_head,
    input  wire          i_empty,
    output logic         o_pop,
    rsr_out_if.source    o_item
);

    logic [5:0] r_idx;

    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_end;
    logic [1:0]                r_out_status;

    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [8:0]                words_sum;
    logic [7:0]                words;
    logic [1:0]                pad;
    logic [5:0]                base;
    logic [5:0]                last;
    logic [5:0]                hdr_sel;
    logic                      advance;
    logic                      at_last;
    logic [7:0]                n_byte;
    logic                      n_end;
    logic [1:0]                n_status;

    // SDES length field: padded chunk size in words.
    assign words_sum = {1'b0, i_head.len} + 9'd10;
    assign words     = {1'b0, words_sum[8:2]};
    // Zero bytes after END to reach a word boundary.
    assign pad       = 2'd1 - i_head.len[1:0];

    assign hdr = {SR_FIRST, SR_TYPE, 8'h00, SR_LEN_WORDS,
                  i_head.ssrc, i_head.ntp_time, i_head.media_time,
                  i_head.sent_packets, i_head.sent_octets,
                  SDES_FIRST, SDES_TYPE, 8'h00, words,
                  i_head.ssrc, CNAME_ITEM, i_head.len, i_head.name_byte};

    assign hdr_sel = 6'(HDR_BYTES - 1) - r_idx;
    assign last    = base + (i_head.finish ? 6'd1 + {4'd0, pad} : 6'd0);
    assign at_last = (r_idx == last);
    assign advance = !i_empty && (!r_out_valid || o_item.ready);
    assign o_pop   = advance && at_last;

    always_comb begin
        base     = 6'd0;
        n_byte   = 8'd0;
        n_end    = 1'b0;
        n_status = ST_OK;
        unique case (i_head.kind)
            CMD_HDR: begin
                base  = 6'(HDR_BYTES - 1);
                if (r_idx <= base) begin
                    n_byte = hdr[hdr_sel];
                end
                n_end = i_head.finish && at_last;
            end
            CMD_NAME: begin
                if (r_idx == 6'd0) begin
                    n_byte = i_head.name_byte;
                end
                n_end = i_head.finish && at_last;
            end
            CMD_ERR: begin
                n_end    = 1'b1;
                n_status = i_head.status;
            end
            default: begin
                n_end = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_last ? 6'd0 : r_idx + 6'd1;
            end else if (o_item.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= n_byte;
            r_out_end    <= n_end;
            r_out_status <= n_status;
        end
    end

    assign o_item.valid      = r_out_valid;
    assign o_item.out_byte   = r_out_byte;
    assign o_item.packet_end = r_out_end;
    assign o_item.status     = r_out_status;

endmodule
`default_nettype wire

[src/rtcp_sender_report_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcp_sender_report_builder
// Builds a compound RTCP packet (sender report plus SDES CNAME) as a byte
// stream in wire order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one item per name byte. The first item of a
// report also carries the NTP and RTP timestamps, the packet and octet
// counts and the name length. The output channel delivers one byte per
// item with an end-of-packet flag and a status code. The source id is
// written through the configuration port while the block is idle.
// The first item of a report yields 39 bytes (sender report, SDES header,
// source id, CNAME type and length, first name byte); each later item
// yields its name byte. The item that ends the name adds the END byte and
// up to three zero bytes of padding. A zero source id or an invalid name
// length yields a single error item, and with a zero source id the rest
// of the name is dropped.
// The first byte of an item reaches the output through the command queue
// and the registered output stage. The serializer emits one byte per cycle
// while the receiver takes bytes, so name bytes flow at one item per cycle;
// a first item holds the serializer for its 39 bytes, plus END and padding
// for a one-byte name, and the closing name item for its name byte, END and
// padding. A command queue of QUEUE_DEPTH entries lets the input run ahead
// meanwhile. Reset clears the queue, the output stage, the name tracking
// and the source id. When the receiver stalls, the output byte holds, the
// serializer waits and the input stops once the queue is full.
// ----------------------------------------------------------------------------
module rtcp_sender_report_builder
    import rsr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [31:0] i_cfg_wr_data,
    rsr_in_if.sink      i_item,
    rsr_out_if.source   o_item
);

    // Commands pass from the front end through the queue to the serializer.
    logic push;
    t_cmd push_cmd;
    logic full;
    logic empty;
    t_cmd head;
    logic pop;

    rsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_full        (full)
    );

    rsr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head),
        .i_pop   (pop)
    );

    // The serializer loads its output register only when it is empty or
    // being drained, so a stalled receiver never loses a byte.
    rsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

[tb/tb_rtcp_sender_report_builder.sv]
// ----------------------------------------------------------------------------
// tb_rtcp_sender_report_builder
// Self-checking bench for the RTCP sender report builder. Report items go
// in on a valid/ready channel and every packet byte that comes out is
// compared with a byte stream predicted inside the bench. A short table of
// hand-picked rows comes first, then several source id settings with
// random reports, random stalls on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_rtcp_sender_report_builder;
    import rsr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 16;      // covers the queue and the output stage
    localparam int HOLD_CYCLES   = 300;     // the one long output stall
    localparam int RAND_ITEMS    = 220;
    localparam int PHASES        = 5;
    localparam int LIMIT_CYCLES  = 1000000;

    // Protocol bytes as the wire format defines them.
    localparam logic [7:0] SR_VERSION_BYTE   = 8'h80;
    localparam logic [7:0] SR_PACKET_TYPE    = 8'd200;
    localparam logic [7:0] SR_WORDS          = 8'd6;
    localparam logic [7:0] SDES_VERSION_BYTE = 8'h81;
    localparam logic [7:0] SDES_PACKET_TYPE  = 8'd202;
    localparam logic [7:0] CNAME_TYPE        = 8'd1;
    localparam int         NAME_LIMIT        = 255;

    // One input item of a report.
    typedef struct packed {
        logic [63:0] ntp_time;
        logic [31:0] media_time;
        logic [31:0] sent_packets;
        logic [31:0] sent_octets;
        logic [7:0]  name_length;
        logic [7:0]  name_byte;
    } t_report_item;

    // One packet byte as the output channel delivers it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic [1:0] status;
    } t_pkt_byte;

    // A row of the directed table. When cfg_wr is set the source id is
    // rewritten, once the block has gone idle, before the row is sent.
    // When typed is set the row must produce exactly one error item with
    // the given status, and that is what gets checked instead of the
    // predicted stream.
    typedef struct packed {
        bit          cfg_wr;
        logic [31:0] cfg_val;
        logic [63:0] ntp_time;
        logic [31:0] media_time;
        logic [31:0] sent_packets;
        logic [31:0] sent_octets;
        logic [7:0]  name_length;
        logic [7:0]  name_byte;
        bit          typed;
        logic [1:0]  typed_status;
    } t_dir_row;

    localparam int DIR_ROWS = 22;

    t_dir_row dir_table [DIR_ROWS] = '{
        // Source id is still zero after reset: one error item, then the
        // remaining four bytes of the five-byte name are swallowed.
        '{1'b0, 32'h0, 64'h0123_4567_89AB_CDEF, 32'h1111_1111, 32'h2222_2222,
          32'h3333_3333, 8'd5, 8'h41, 1'b1, ST_NO_SOURCE},
        '{1'b0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'hAAAA_AAAA_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h0F0F_0F0F, 8'd1, 8'h5A, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd3, 8'hA5, 1'b0, ST_OK},
        // A one-byte name with a zero source id leaves nothing to drop.
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd1, 8'h00, 1'b1, ST_NO_SOURCE},
        // An empty name with a zero source id reports the source id first.
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h7F, 1'b1, ST_NO_SOURCE},
        // All-ones source id, empty name.
        '{1'b1, 32'hFFFF_FFFF, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h80, 1'b1,
          ST_BAD_NAME},
        // One-byte names finish on the first item, all-ones then all-zero.
        '{1'b0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 8'd1, 8'hFF, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd1, 8'h00, 1'b0, ST_OK},
        // Three-byte name with two bytes of padding. The source id is
        // cleared after the first item, which must not touch this packet.
        '{1'b1, 32'h0000_0001, 64'h8000_0000_0000_0001, 32'h8000_0000,
          32'h0000_0001, 32'hAAAA_5555, 8'd3, 8'h61, 1'b0, ST_OK},
        '{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h62, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h63, 1'b0, ST_OK},
        // The next report sees the cleared source id and drops one byte.
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd2, 8'h64, 1'b1, ST_NO_SOURCE},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd9, 8'h65, 1'b0, ST_OK},
        // Two-byte name, three bytes of padding.
        '{1'b1, 32'h89AB_CDEF, 64'hDEAD_BEEF_0BAD_F00D, 32'h5555_AAAA,
          32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'd2, 8'h01, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd200, 8'hFE, 1'b0, ST_OK},
        // Five-byte name lands on a word boundary, so END carries the end flag.
        '{1'b0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFE, 32'h0000_FFFF, 32'hFFFF_0000,
          32'h1234_5678, 8'd5, 8'h10, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h11, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h12, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h13, 1'b0, ST_OK},
        '{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'h14, 1'b0, ST_OK}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    rsr_in_if  in_ch ();
    rsr_out_if out_ch ();

    rtcp_sender_report_builder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_item       (in_ch),
        .o_item       (out_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Shadow of the block's state, kept at reset values until written.
    logic [31:0] ssrc_shadow = '0;
    int unsigned cname_pos = 0;     // name bytes taken, zero between reports
    int unsigned cname_len = 0;     // name length of the report in progress
    bit          discarding = 1'b0; // swallowing the rest of a rejected name

    // Bytes produced by the item being predicted, and every byte that has
    // been predicted but has not yet come out of the block.
    t_pkt_byte burst [$];
    t_pkt_byte expected_bytes [$];

    int err_count     = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int reports_seen  = 0;
    int error_items   = 0;
    int settings_used = 0;
    int longest_name  = 0;

    // Idling controls. The calm flags switch off gaps for stretches.
    bit tx_calm    = 1'b0;
    bit rx_calm    = 1'b0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    function automatic void push_byte(input logic [7:0] b, input logic e,
                                      input logic [1:0] s);
        t_pkt_byte pb;
        pb.out_byte   = b;
        pb.packet_end = e;
        pb.status     = s;
        burst = {burst, pb};
    endfunction

    // Big-endian, most significant byte first.
    function automatic void push_word(input logic [31:0] w);
        push_byte(w[31:24], 1'b0, ST_OK);
        push_byte(w[23:16], 1'b0, ST_OK);
        push_byte(w[15:8],  1'b0, ST_OK);
        push_byte(w[7:0],   1'b0, ST_OK);
    endfunction

    // The SDES chunk before END holds the source id, type, length and the
    // name. END and zero padding bring it up to a whole number of words, and
    // the end flag sits on whichever byte is last.
    function automatic void close_name();
        int unsigned unpadded;
        int unsigned pad;
        unpadded = 7 + cname_len;
        pad = (4 - (unpadded % 4)) % 4;
        push_byte(8'h00, pad == 0, ST_OK);
        for (int unsigned k = 0; k < pad; k++)
            push_byte(8'h00, k + 1 == pad, ST_OK);
        cname_pos = 0;
        cname_len = 0;
    endfunction

    // Works out the bytes that one accepted item causes and advances the
    // shadow state. The result lands in burst.
    function automatic void serialize_item(input t_report_item it);
        int unsigned len;
        int unsigned sdes_words;
        burst.delete();

        // Follow-on item of a report: one name byte, or nothing while a
        // rejected name is being swallowed.
        if (cname_pos != 0) begin
            cname_pos++;
            if (discarding) begin
                if (cname_pos >= cname_len) begin
                    discarding = 1'b0;
                    cname_pos  = 0;
                    cname_len  = 0;
                end
                return;
            end
            push_byte(it.name_byte, 1'b0, ST_OK);
            if (cname_pos >= cname_len)
                close_name();
            return;
        end

        len = it.name_length;
        // The source id is checked ahead of the name length.
        if (ssrc_shadow == 0) begin
            push_byte(8'h00, 1'b1, ST_NO_SOURCE);
            if (len >= 2 && len <= NAME_LIMIT) begin
                discarding = 1'b1;
                cname_len  = len;
                cname_pos  = 1;
            end
            return;
        end
        if (len == 0 || len > NAME_LIMIT) begin
            push_byte(8'h00, 1'b1, ST_BAD_NAME);
            return;
        end

        // Sender report.
        push_byte(SR_VERSION_BYTE, 1'b0, ST_OK);
        push_byte(SR_PACKET_TYPE, 1'b0, ST_OK);
        push_byte(8'h00, 1'b0, ST_OK);
        push_byte(SR_WORDS, 1'b0, ST_OK);
        push_word(ssrc_shadow);
        push_word(it.ntp_time[63:32]);
        push_word(it.ntp_time[31:0]);
        push_word(it.media_time);
        push_word(it.sent_packets);
        push_word(it.sent_octets);

        // SDES header; the length field is the padded chunk in words.
        sdes_words = (len + 10) / 4;
        push_byte(SDES_VERSION_BYTE, 1'b0, ST_OK);
        push_byte(SDES_PACKET_TYPE, 1'b0, ST_OK);
        push_byte(sdes_words[15:8], 1'b0, ST_OK);
        push_byte(sdes_words[7:0], 1'b0, ST_OK);
        push_word(ssrc_shadow);
        push_byte(CNAME_TYPE, 1'b0, ST_OK);
        push_byte(len[7:0], 1'b0, ST_OK);
        push_byte(it.name_byte, 1'b0, ST_OK);

        cname_pos = 1;
        cname_len = len;
        if (cname_pos >= cname_len)
            close_name();
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_report_item random_item(input logic [7:0] len);
        t_report_item it;
        it.ntp_time     = {$urandom, $urandom};
        it.media_time   = $urandom;
        it.sent_packets = $urandom;
        it.sent_octets  = $urandom;
        it.name_length  = len;
        it.name_byte    = $urandom_range(0, 255);
        return it;
    endfunction

    // Offers one item and holds it until the block takes it. Valid is left
    // high so that back-to-back items need no second assignment in a step.
    task automatic send_item(input t_report_item it, input bit typed,
                             input logic [1:0] typed_status);
        t_pkt_byte err_byte;
        in_ch.valid        <= 1'b1;
        in_ch.ntp_time     <= it.ntp_time;
        in_ch.media_time   <= it.media_time;
        in_ch.sent_packets <= it.sent_packets;
        in_ch.sent_octets  <= it.sent_octets;
        in_ch.name_length  <= it.name_length;
        in_ch.name_byte    <= it.name_byte;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);

        if (cname_pos == 0) begin
            reports_seen++;
            if (it.name_length > longest_name)
                longest_name = it.name_length;
        end
        serialize_item(it);
        if (typed) begin
            err_byte.out_byte   = 8'h00;
            err_byte.packet_end = 1'b1;
            err_byte.status     = typed_status;
            burst = '{err_byte};
        end
        expected_bytes = {expected_bytes, burst};
        items_sent++;
    endtask

    task automatic idle_after_item();
        int n;
        n = tx_calm ? 0 : pick_gap();
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted byte has come out,
    // then lets items that cause no bytes clear the pipeline.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ssrc(input logic [31:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ssrc_shadow = value;
        settings_used++;
    endtask

    // A first item with the given name length, then follow-on items for as
    // long as the report (or the swallowed name) is still open.
    task automatic send_report(input logic [7:0] len);
        send_item(random_item(len), 1'b0, ST_OK);
        idle_after_item();
        while (cname_pos != 0) begin
            send_item(random_item($urandom_range(0, 255)), 1'b0, ST_OK);
            idle_after_item();
        end
    endtask

    // Output side: checks every byte taken and decides ready for the next
    // cycle. The long hold runs once, on request from the stimulus, and is
    // counted here so that the sender keeps offering items meanwhile.
    task automatic check_byte();
        t_pkt_byte want;
        if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %h end %b status %0d",
                                    out_ch.out_byte, out_ch.packet_end,
                                    out_ch.status));
        end else begin
            want = expected_bytes.pop_front();
            if (out_ch.out_byte !== want.out_byte)
                flag_mismatch($sformatf("byte %0d: out_byte %h, expected %h",
                                        bytes_checked, out_ch.out_byte,
                                        want.out_byte));
            if (out_ch.packet_end !== want.packet_end)
                flag_mismatch($sformatf("byte %0d: packet_end %b, expected %b",
                                        bytes_checked, out_ch.packet_end,
                                        want.packet_end));
            if (out_ch.status !== want.status)
                flag_mismatch($sformatf("byte %0d: status %0d, expected %0d",
                                        bytes_checked, out_ch.status,
                                        want.status));
            if (want.status != ST_OK)
                error_items++;
        end
        bytes_checked++;
    endtask

    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            check_byte();

        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            stall_left = rx_calm ? 0 : pick_gap();
            out_ch.ready <= 1'b1;
        end
    end

    // Main stimulus.
    initial begin
        logic [31:0]  phase_ssrc [PHASES];
        t_report_item it;
        int           phase_start;
        int           r;
        logic [7:0]   len;

        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.ntp_time     <= '0;
        in_ch.media_time   <= '0;
        in_ch.sent_packets <= '0;
        in_ch.sent_octets  <= '0;
        in_ch.name_length  <= '0;
        in_ch.name_byte    <= '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The first rows run on the reset source id of zero.
        foreach (dir_table[i]) begin
            if (dir_table[i].cfg_wr) begin
                settle();
                write_ssrc(dir_table[i].cfg_val);
            end
            it.ntp_time     = dir_table[i].ntp_time;
            it.media_time   = dir_table[i].media_time;
            it.sent_packets = dir_table[i].sent_packets;
            it.sent_octets  = dir_table[i].sent_octets;
            it.name_length  = dir_table[i].name_length;
            it.name_byte    = dir_table[i].name_byte;
            send_item(it, dir_table[i].typed, dir_table[i].typed_status);
            idle_after_item();
        end

        // Random reports under several source ids, the extremes among them.
        // A zero source id phase exercises the swallowed names with random
        // lengths.
        phase_ssrc = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0, $urandom, $urandom};
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_ssrc(phase_ssrc[p]);
            // The long output stall starts as this phase begins, so the
            // header items pile up in the block and stall its input.
            if (p == 1)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < RAND_ITEMS / PHASES) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 8'd0;
                else if (r < 80)
                    len = $urandom_range(1, 8);
                else if (r < 97)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 96);
                send_report(len);
            end
        end

        settle();
        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d predicted bytes never came out",
                                    expected_bytes.size()));

        $display("Sent %0d items forming %0d reports under %0d source id settings.",
                 items_sent, reports_seen, settings_used);
        $display("Checked %0d packet bytes, %0d of them error items; longest name %0d.",
                 bytes_checked, error_items, longest_name);
        if (err_count == 0)
            $display("rtcp_sender_report_builder verification clean");
        else
            $display("rtcp_sender_report_builder verification failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("rtcp_sender_report_builder verification failed");
        $finish;
    end

endmodule

[rtcp_sender_report_builder.f]
src/rsr_pkg.sv
src/rsr_if.sv
src/rsr_front.sv
src/rsr_queue.sv
src/rsr_back.sv
src/rtcp_sender_report_builder.sv
tb/tb_rtcp_sender_report_builder.sv
